[hw/rtl/scsp_pkg.sv]
// Shared constants for the segment closest-points pipeline.
// No dependencies; used by point stage, top level, checker and bench.
package scsp_pkg;

  // Width and reset value of the degenerate-length threshold register.
  localparam int THR_W = 32;
  localparam logic [THR_W-1:0] THR_RESET = 32'd4295;

  // Width of the saturating squared-distance result.
  localparam int DIST_W = 64;

endpackage

[hw/rtl/scsp_delay.sv]
// Plain delay line for payload that rides beside the long pipeline units.
// No dependencies; advances only when the pipeline enable is high.
module scsp_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] pipe_q [DEPTH];

  // Shift the whole line by one place on each enabled cycle.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
        pipe_q[k] <= pipe_q[k-1];
      end
    end
  end

  assign q_o = pipe_q[DEPTH-1];

endmodule

[hw/rtl/scsp_div.sv]
// Pipelined restoring divider giving clamp(num/den, 0, 1) in Q1.FB, truncated.
// No dependencies; entry stage settles clamps, then one quotient bit per stage.
module scsp_div #(
  parameter int NW = 16,
  parameter int QW = 17
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [NW-1:0] num_i,
  input  logic signed [NW-1:0] den_i,
  output logic [QW-1:0]        q_o
);

  localparam int FB = QW - 1;

  logic [NW-1:0] rem_q  [FB+1];
  logic [NW-1:0] den_q  [FB+1];
  logic [FB-1:0] quo_q  [FB+1];
  logic          zero_q [FB+1];
  logic          one_q  [FB+1];
  logic          num_le0;
  logic          num_ge;

  // Entry stage: settle the clamped cases before the bit steps.
  assign num_le0 = num_i[NW-1] || (num_i == '0);
  assign num_ge  = (num_i >= den_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num_i;
      den_q[0]  <= den_i;
      quo_q[0]  <= '0;
      zero_q[0] <= num_le0;
      one_q[0]  <= !num_le0 && num_ge;
    end
  end

  // One shift-and-subtract step per stage; the remainder stays below den.
  for (genvar k = 1; k <= FB; k++) begin : g_step
    logic [NW-1:0] dbl;
    logic          fit;

    assign dbl = {rem_q[k-1][NW-2:0], 1'b0};
    assign fit = (dbl >= den_q[k-1]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= fit ? (dbl - den_q[k-1]) : dbl;
        den_q[k]  <= den_q[k-1];
        quo_q[k]  <= {quo_q[k-1][FB-2:0], fit};
        zero_q[k] <= zero_q[k-1];
        one_q[k]  <= one_q[k-1];
      end
    end
  end

  assign q_o = one_q[FB]  ? {1'b1, {FB{1'b0}}} :
               zero_q[FB] ? '0 : {1'b0, quo_q[FB]};

endmodule

[hw/rtl/scsp_point.sv]
// Back end: closest points from s and t, their difference and squared distance.
// Depends on scsp_pkg for the distance width; five register stages.
module scsp_point import scsp_pkg::*; #(
  parameter int CW = 32,
  parameter int FB = 16
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [6*CW+6*(CW+1)-1:0]  geo_i,
  input  logic [FB:0]               s_i,
  input  logic [FB:0]               t_i,
  output logic [6*CW-1:0]           pt_o,
  output logic [FB:0]               s_o,
  output logic [FB:0]               t_o,
  output logic [DIST_W-1:0]         dist_o
);

  localparam int DW  = CW + 1;
  localparam int QW  = FB + 1;
  localparam int PRW = DW + QW + 1;
  localparam int EW  = CW + 3;
  localparam int FW  = EW + 1;
  localparam int SQW = 2 * FW + 2;
  localparam logic signed [PRW-1:0] HALF = PRW'(1) << (FB - 1);

  logic signed [CW-1:0]  st_c   [6];
  logic signed [DW-1:0]  dir_c  [6];
  logic signed [CW-1:0]  stD_q  [6];
  logic signed [PRW-1:0] prodD_q [6];
  logic [QW-1:0]         sD_q, tD_q, sE_q, tE_q, sF_q, tF_q, sG_q, tG_q, sH_q, tH_q;
  logic signed [PRW-1:0] rnd_c  [6];
  logic signed [PRW-1:0] sh_c   [6];
  logic signed [EW-1:0]  ptE_q  [6];
  logic signed [FW-1:0]  dfF_q  [3];
  logic [6*CW-1:0]       ptF_q, ptG_q, ptH_q;
  logic signed [2*FW-1:0] sqG_q [3];
  logic signed [SQW-1:0] sum_c;
  logic [DIST_W-1:0]     dist_c;
  logic [DIST_W-1:0]     distH_q;

  // Unpack start points and directions; A first, then B.
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      st_c[i]  = $signed(geo_i[i*CW +: CW]);
      dir_c[i] = $signed(geo_i[6*CW + i*DW +: DW]);
    end
  end

  // Stage D: direction times parameter.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        prodD_q[i]   <= dir_c[i] * $signed({1'b0, s_i});
        prodD_q[3+i] <= dir_c[3+i] * $signed({1'b0, t_i});
      end
      for (int i = 0; i < 6; i++) begin
        stD_q[i] <= st_c[i];
      end
      sD_q <= s_i;
      tD_q <= t_i;
    end
  end

  // Stage E: round half up to the coordinate step and add the start point.
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      rnd_c[i] = prodD_q[i] + HALF;
      sh_c[i]  = rnd_c[i] >>> FB;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 6; i++) begin
        ptE_q[i] <= EW'(stD_q[i]) + sh_c[i][EW-1:0];
      end
      sE_q <= sD_q;
      tE_q <= tD_q;
    end
  end

  // Stage F: difference between the two points.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        dfF_q[i] <= FW'(ptE_q[i]) - FW'(ptE_q[3+i]);
      end
      for (int i = 0; i < 6; i++) begin
        ptF_q[i*CW +: CW] <= ptE_q[i][CW-1:0];
      end
      sF_q <= sE_q;
      tF_q <= tE_q;
    end
  end

  // Stage G: squares of the differences.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sqG_q[i] <= dfF_q[i] * dfF_q[i];
      end
      ptG_q <= ptF_q;
      sG_q  <= sF_q;
      tG_q  <= tF_q;
    end
  end

  // Stage H: sum and saturate to the distance width.
  assign sum_c = SQW'(sqG_q[0]) + SQW'(sqG_q[1]) + SQW'(sqG_q[2]);

  if (SQW > DIST_W) begin : g_sat
    assign dist_c = (|sum_c[SQW-1:DIST_W]) ? '1 : sum_c[DIST_W-1:0];
  end else begin : g_nosat
    assign dist_c = DIST_W'($unsigned(sum_c));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      distH_q <= dist_c;
      ptH_q   <= ptG_q;
      sH_q    <= sG_q;
      tH_q    <= tG_q;
    end
  end

  assign pt_o   = ptH_q;
  assign s_o    = sH_q;
  assign t_o    = tH_q;
  assign dist_o = distH_q;

endmodule

[hw/rtl/segment_segment_closest_points.sv]
// Top level of the segment closest-points pipeline.
// Depends on scsp_pkg, scsp_delay, scsp_div and scsp_point.
//
//  channel  | dir | handshake             | content
//  s_axis   | in  | tvalid/tready         | one segment pair per item
//  m_axis   | out | tvalid/tready         | closest points, s, t, squared distance
//  cfg      | in  | cfg_we_i              | degenerate length threshold
//
// The two chained quotient pipelines have FRAC_BITS+1 stages each; one item
// enters per cycle unless stalled. The whole pipeline advances whenever the
// output register is empty or read, so a stall holds every stage in place.
// Reset clears the valid bits and sets the threshold to 4295.
module segment_segment_closest_points import scsp_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
  // b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z
  input  logic [((12*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // closest_a_x/y/z, closest_b_x/y/z, param_a, param_b, dist_squared, zero pad
  output logic [((6*COORD_WIDTH+2*(FRAC_BITS+1)+DIST_W+7)/8)*8-1:0] m_axis_tdata,
  input  logic                 cfg_we_i,
  input  logic [THR_W-1:0]     cfg_wdata_i
);

  localparam int CW    = COORD_WIDTH;
  localparam int FB    = FRAC_BITS;
  localparam int QW    = FB + 1;
  localparam int DW    = CW + 1;
  localparam int MW    = 2 * DW;
  localparam int SW    = MW + 2;
  localparam int LL    = (SW + 1) / 2;
  localparam int HL    = SW - LL;
  localparam int NW2   = SW + 2;
  localparam int PW    = 2 * SW;
  localparam int NW1   = PW + 2;
  localparam int BSW   = SW + QW + 1;
  localparam int TW    = BSW + 2;
  localparam int GEO_W = 6 * CW + 6 * DW;
  localparam int OUT_W = ((6*CW + 2*QW + DIST_W + 7) / 8) * 8;
  localparam int LAT   = 2 * FB + 16;
  localparam int SB1_W = SW + 2 * NW2 + 3;
  localparam int SB2_W = 4 * QW + 4;
  localparam logic [QW-1:0] P_ONE = {1'b1, {FB{1'b0}}};

  logic               en;
  logic [LAT-1:0]     vld_q;
  logic [THR_W-1:0]   thr_q;

  logic signed [CW-1:0] in_c [12];
  logic signed [DW-1:0] d1_c [3], d2_c [3], r_c [3];
  logic [GEO_W-1:0]     geo_c, geoC;

  logic signed [DW-1:0] d1_q [3], d2_q [3], r_q [3];
  logic signed [MW-1:0] aa_q [3], ee_q [3], ff_q [3], cc_q [3], bb_q [3];
  logic signed [SW-1:0] a_q, e_q, f_q, c_q, b_q;
  logic signed [SW-1:0] thr_ext;

  logic signed [SW-1:0]   mx_c [4], my_c [4];
  logic signed [2*HL-1:0] phh4_q [4];
  logic signed [HL+LL:0]  phl4_q [4], plh4_q [4];
  logic signed [2*LL+1:0] pll4_q [4];
  logic signed [PW-1:0]   prod_c [4], prod4b_q [4];
  logic signed [NW2-1:0] negc4_q, bmc4_q, f4_q, e4_q, a4_q;
  logic signed [SW-1:0]  b4_q;
  logic                  adeg4_q, edeg4_q;
  logic signed [NW2-1:0] negc4b_q, bmc4b_q, f4b_q, e4b_q, a4b_q;
  logic signed [SW-1:0]  b4b_q;
  logic                  adeg4b_q, edeg4b_q;

  logic signed [NW1-1:0] den5_q, nums5_q;
  logic signed [NW2-1:0] negc5_q, bmc5_q, f5_q, e5_q, a5_q;
  logic signed [SW-1:0]  b5_q;
  logic                  adeg5_q, edeg5_q, dz5_q;

  logic [QW-1:0]         q_s1, q_negc, q_bmc, q_fe, q_t;
  logic [SB1_W-1:0]      sb1_out;
  logic signed [SW-1:0]  b6;
  logic signed [NW2-1:0] f6, e6;
  logic                  adeg6, edeg6, dz6;
  logic [QW-1:0]         s1_c;

  logic [QW-1:0]         sA_q, pnegcA_q, pbmcA_q, pfeA_q;
  logic signed [BSW-1:0] bsA_q;
  logic signed [NW2-1:0] fA_q, eA_q;
  logic                  adegA_q, edegA_q;

  logic signed [TW-1:0]  tn_c, td_c, tnB_q, tdB_q;
  logic [QW-1:0]         sB_q, pnegcB_q, pbmcB_q, pfeB_q;
  logic                  adegB_q, edegB_q, tnegB_q, tgtB_q;

  logic [SB2_W-1:0]      sb2_out;
  logic [QW-1:0]         s9, pnegc9, pbmc9, pfe9;
  logic                  adeg9, edeg9, tneg9, tgt9;
  logic [QW-1:0]         s_c, t_c, sC_q, tC_q;

  logic [6*CW-1:0]       pt_w;
  logic [QW-1:0]         s_w, t_w;
  logic [DIST_W-1:0]     dist_w;

  // Pipeline moves whenever the output register is free or being read.
  assign en            = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];

  // Valid bits travel with the items.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // Threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Unpack the item, form the direction and offset vectors.
  always_comb begin
    for (int i = 0; i < 12; i++) begin
      in_c[i] = $signed(s_axis_tdata[i*CW +: CW]);
    end
    for (int i = 0; i < 3; i++) begin
      d1_c[i] = DW'(in_c[3+i]) - DW'(in_c[i]);
      d2_c[i] = DW'(in_c[9+i]) - DW'(in_c[6+i]);
      r_c[i]  = DW'(in_c[i]) - DW'(in_c[6+i]);
    end
    geo_c = '0;
    for (int i = 0; i < 3; i++) begin
      geo_c[i*CW +: CW]             = in_c[i];
      geo_c[(3+i)*CW +: CW]         = in_c[6+i];
      geo_c[6*CW + i*DW +: DW]      = d1_c[i];
      geo_c[6*CW + (3+i)*DW +: DW]  = d2_c[i];
    end
  end

  // Geometry waits beside the arithmetic until s and t are known.
  scsp_delay #(.W(GEO_W), .DEPTH(2*FB+11)) u_geo_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (geo_c),
    .q_o   (geoC)
  );

  // Stage 1: register the vectors.
  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_q <= d1_c;
      d2_q <= d2_c;
      r_q  <= r_c;
    end
  end

  // Stage 2: component products of the dot products.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        aa_q[i] <= d1_q[i] * d1_q[i];
        ee_q[i] <= d2_q[i] * d2_q[i];
        ff_q[i] <= d2_q[i] * r_q[i];
        cc_q[i] <= d1_q[i] * r_q[i];
        bb_q[i] <= d1_q[i] * d2_q[i];
      end
    end
  end

  // Stage 3: dot product sums.
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= SW'(aa_q[0]) + SW'(aa_q[1]) + SW'(aa_q[2]);
      e_q <= SW'(ee_q[0]) + SW'(ee_q[1]) + SW'(ee_q[2]);
      f_q <= SW'(ff_q[0]) + SW'(ff_q[1]) + SW'(ff_q[2]);
      c_q <= SW'(cc_q[0]) + SW'(cc_q[1]) + SW'(cc_q[2]);
      b_q <= SW'(bb_q[0]) + SW'(bb_q[1]) + SW'(bb_q[2]);
    end
  end

  // Operands of the cross products: a*e, b*b, b*f and c*e.
  always_comb begin
    mx_c[0] = a_q;
    my_c[0] = e_q;
    mx_c[1] = b_q;
    my_c[1] = b_q;
    mx_c[2] = b_q;
    my_c[2] = f_q;
    mx_c[3] = c_q;
    my_c[3] = e_q;
  end

  // Stage 4: degenerate tests, divider numerators and the partial products
  // of the cross products, each operand split into a signed high half and an
  // unsigned low half.
  assign thr_ext = $signed({{(SW-THR_W){1'b0}}, thr_q});

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        phh4_q[j] <= $signed(mx_c[j][SW-1:LL]) * $signed(my_c[j][SW-1:LL]);
        phl4_q[j] <= $signed(mx_c[j][SW-1:LL]) * $signed({1'b0, my_c[j][LL-1:0]});
        plh4_q[j] <= $signed({1'b0, mx_c[j][LL-1:0]}) * $signed(my_c[j][SW-1:LL]);
        pll4_q[j] <= $signed({1'b0, mx_c[j][LL-1:0]}) *
                     $signed({1'b0, my_c[j][LL-1:0]});
      end
      adeg4_q <= (a_q <= thr_ext);
      edeg4_q <= (e_q <= thr_ext);
      negc4_q <= -NW2'(c_q);
      bmc4_q  <= NW2'(b_q) - NW2'(c_q);
      f4_q    <= NW2'(f_q);
      e4_q    <= NW2'(e_q);
      a4_q    <= NW2'(a_q);
      b4_q    <= b_q;
    end
  end

  // Stage 4b: combine the partial products; the other values move along.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      prod_c[j] = (PW'(phh4_q[j]) <<< (2 * LL)) + (PW'(phl4_q[j]) <<< LL) +
                  (PW'(plh4_q[j]) <<< LL) + PW'(pll4_q[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod4b_q <= prod_c;
      negc4b_q <= negc4_q;
      bmc4b_q  <= bmc4_q;
      f4b_q    <= f4_q;
      e4b_q    <= e4_q;
      a4b_q    <= a4_q;
      b4b_q    <= b4_q;
      adeg4b_q <= adeg4_q;
      edeg4b_q <= edeg4_q;
    end
  end

  // Stage 5: denominator and numerator of the unclamped s.
  always_ff @(posedge clk_i) begin
    if (en) begin
      den5_q  <= NW1'(prod4b_q[0]) - NW1'(prod4b_q[1]);
      nums5_q <= NW1'(prod4b_q[2]) - NW1'(prod4b_q[3]);
      dz5_q   <= (prod4b_q[0] == prod4b_q[1]);
      negc5_q <= negc4b_q;
      bmc5_q  <= bmc4b_q;
      f5_q    <= f4b_q;
      e5_q    <= e4b_q;
      a5_q    <= a4b_q;
      b5_q    <= b4b_q;
      adeg5_q <= adeg4b_q;
      edeg5_q <= edeg4b_q;
    end
  end

  // Four quotients in parallel: s from the full solve, and the fallbacks.
  scsp_div #(.NW(NW1), .QW(QW)) u_div_s (
    .clk_i (clk_i), .en_i (en), .num_i (nums5_q), .den_i (den5_q), .q_o (q_s1)
  );

  scsp_div #(.NW(NW2), .QW(QW)) u_div_negc (
    .clk_i (clk_i), .en_i (en), .num_i (negc5_q), .den_i (a5_q), .q_o (q_negc)
  );

  scsp_div #(.NW(NW2), .QW(QW)) u_div_bmc (
    .clk_i (clk_i), .en_i (en), .num_i (bmc5_q), .den_i (a5_q), .q_o (q_bmc)
  );

  scsp_div #(.NW(NW2), .QW(QW)) u_div_fe (
    .clk_i (clk_i), .en_i (en), .num_i (f5_q), .den_i (e5_q), .q_o (q_fe)
  );

  scsp_delay #(.W(SB1_W), .DEPTH(QW)) u_sb1_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({b5_q, f5_q, e5_q, adeg5_q, edeg5_q, dz5_q}),
    .q_o   (sb1_out)
  );

  assign {b6, f6, e6, adeg6, edeg6, dz6} = sb1_out;

  // Parallel segments take s = 0 before the t step.
  assign s1_c = dz6 ? '0 : q_s1;

  // Stage A: b times the quantised s.
  always_ff @(posedge clk_i) begin
    if (en) begin
      bsA_q    <= b6 * $signed({1'b0, s1_c});
      sA_q     <= s1_c;
      fA_q     <= f6;
      eA_q     <= e6;
      pnegcA_q <= q_negc;
      pbmcA_q  <= q_bmc;
      pfeA_q   <= q_fe;
      adegA_q  <= adeg6;
      edegA_q  <= edeg6;
    end
  end

  // Stage B: numerator and denominator of t, and its range checks.
  assign tn_c = TW'(bsA_q) + (TW'(fA_q) <<< FB);
  assign td_c = TW'(eA_q) <<< FB;

  always_ff @(posedge clk_i) begin
    if (en) begin
      tnB_q    <= tn_c;
      tdB_q    <= td_c;
      tnegB_q  <= tn_c[TW-1];
      tgtB_q   <= (tn_c > td_c);
      sB_q     <= sA_q;
      pnegcB_q <= pnegcA_q;
      pbmcB_q  <= pbmcA_q;
      pfeB_q   <= pfeA_q;
      adegB_q  <= adegA_q;
      edegB_q  <= edegA_q;
    end
  end

  scsp_div #(.NW(TW), .QW(QW)) u_div_t (
    .clk_i (clk_i), .en_i (en), .num_i (tnB_q), .den_i (tdB_q), .q_o (q_t)
  );

  scsp_delay #(.W(SB2_W), .DEPTH(QW)) u_sb2_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({sB_q, pnegcB_q, pbmcB_q, pfeB_q, adegB_q, edegB_q, tnegB_q, tgtB_q}),
    .q_o   (sb2_out)
  );

  assign {s9, pnegc9, pbmc9, pfe9, adeg9, edeg9, tneg9, tgt9} = sb2_out;

  // Stage C: pick s and t for the degenerate and clamped cases.
  always_comb begin
    if (adeg9 && edeg9) begin
      s_c = '0;
      t_c = '0;
    end else if (adeg9) begin
      s_c = '0;
      t_c = pfe9;
    end else if (edeg9) begin
      s_c = pnegc9;
      t_c = '0;
    end else if (tneg9) begin
      s_c = pnegc9;
      t_c = '0;
    end else if (tgt9) begin
      s_c = pbmc9;
      t_c = P_ONE;
    end else begin
      s_c = s9;
      t_c = q_t;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sC_q <= s_c;
      tC_q <= t_c;
    end
  end

  // Points, difference and distance; its last stage is the output register.
  scsp_point #(.CW(CW), .FB(FB)) u_point (
    .clk_i  (clk_i),
    .en_i   (en),
    .geo_i  (geoC),
    .s_i    (sC_q),
    .t_i    (tC_q),
    .pt_o   (pt_w),
    .s_o    (s_w),
    .t_o    (t_w),
    .dist_o (dist_w)
  );

  assign m_axis_tdata = OUT_W'({dist_w, t_w, s_w, pt_w});

endmodule

[tb/scsp_checker.sv]
// Checker for the segment closest-points pipeline: watches both streams and the
// threshold port, predicts every result and compares it field by field.
// Depends on scsp_pkg only.
`timescale 1ns / 1ps

module scsp_checker import scsp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [383:0]      s_axis_tdata,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [295:0]      m_axis_tdata,
  input  logic              cfg_we_i,
  input  logic [THR_W-1:0]  cfg_wdata_i,
  output int                fail_count_o,
  output int                pending_o
);

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic [5:0][31:0] pts;     // closest A x/y/z, then closest B x/y/z
    logic [16:0]      s_par;
    logic [16:0]      t_par;
    logic [63:0]      dist_sq;
  } closest_t;

  closest_t         expected_q[$];
  logic [THR_W-1:0] threshold;
  int               fails;
  int               pending;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  // Clamped quotient in Q1.16, truncated toward zero; den is positive.
  function automatic logic [16:0] clamped_ratio(input wide_t num, input wide_t den);
    wide_t q;
    if (num <= 0) return 17'd0;
    if (num >= den) return 17'h10000;
    q = (num <<< 16) / den;
    return q[16:0];
  endfunction

  // Point on a segment: start + round(d * p), halves rounded up.
  function automatic wide_t seg_point(input wide_t base, input wide_t dir,
                                      input logic [16:0] p);
    wide_t pw;
    pw = $signed({239'd0, p});
    return base + ((dir * pw + 256'sd32768) >>> 16);
  endfunction

  function automatic closest_t closest_points(input logic [383:0] pair,
                                              input logic [THR_W-1:0] thr);
    wide_t p1[3], q1[3], d1[3], d2[3], rr[3], pa[3], pb[3], df[3];
    wide_t a, e, f, c, b, den, tn, td, dsq, thr_w;
    logic [16:0] s, t;
    closest_t res;
    for (int i = 0; i < 3; i++) begin
      p1[i] = $signed(pair[32*i +: 32]);
      d1[i] = $signed(pair[32*(3+i) +: 32]);
      d1[i] = d1[i] - p1[i];
      q1[i] = $signed(pair[32*(6+i) +: 32]);
      d2[i] = $signed(pair[32*(9+i) +: 32]);
      d2[i] = d2[i] - q1[i];
      rr[i] = p1[i] - q1[i];
    end
    a = d1[0]*d1[0] + d1[1]*d1[1] + d1[2]*d1[2];
    e = d2[0]*d2[0] + d2[1]*d2[1] + d2[2]*d2[2];
    f = d2[0]*rr[0] + d2[1]*rr[1] + d2[2]*rr[2];
    c = d1[0]*rr[0] + d1[1]*rr[1] + d1[2]*rr[2];
    b = d1[0]*d2[0] + d1[1]*d2[1] + d1[2]*d2[2];
    thr_w = $signed({224'd0, thr});
    s = '0;
    t = '0;
    if (a <= thr_w && e <= thr_w) begin
      // Both segments are points: the two start points.
    end else if (a <= thr_w) begin
      t = clamped_ratio(f, e);
    end else if (e <= thr_w) begin
      s = clamped_ratio(-c, a);
    end else begin
      den = a*e - b*b;
      // Parallel segments keep s at zero before the t step.
      s  = (den == 0) ? 17'd0 : clamped_ratio(b*f - c*e, den);
      tn = b * $signed({239'd0, s}) + (f <<< 16);
      td = e <<< 16;
      if (tn < 0) begin
        t = '0;
        s = clamped_ratio(-c, a);
      end else if (tn > td) begin
        t = 17'h10000;
        s = clamped_ratio(b - c, a);
      end else begin
        t = clamped_ratio(tn, td);
      end
    end
    for (int i = 0; i < 3; i++) begin
      pa[i] = seg_point(p1[i], d1[i], s);
      pb[i] = seg_point(q1[i], d2[i], t);
      df[i] = pa[i] - pb[i];
      res.pts[i]   = pa[i][31:0];
      res.pts[3+i] = pb[i][31:0];
    end
    dsq = df[0]*df[0] + df[1]*df[1] + df[2]*df[2];
    res.s_par   = s;
    res.t_par   = t;
    res.dist_sq = (dsq[255:64] != 0) ? {64{1'b1}} : dsq[63:0];
    return res;
  endfunction

  // Track the threshold, predict on each accepted input item and check each
  // accepted output item against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    closest_t want, got;
    if (!rst_ni) begin
      threshold = THR_RESET;
      fails     = 0;
      expected_q.delete();
      pending   = 0;
    end else begin
      if (cfg_we_i) threshold = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(closest_points(s_axis_tdata, threshold));
      if (m_axis_tvalid && m_axis_tready) begin
        got.pts     = m_axis_tdata[191:0];
        got.s_par   = m_axis_tdata[208:192];
        got.t_par   = m_axis_tdata[225:209];
        got.dist_sq = m_axis_tdata[289:226];
        if (expected_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result item %h", $time, m_axis_tdata);
        end else begin
          want = expected_q.pop_front();
          for (int i = 0; i < 6; i++)
            if (want.pts[i] !== got.pts[i]) begin
              fails++;
              $display("%0t: closest %s %s: expected %h, actual %h", $time,
                       (i < 3) ? "a" : "b", (i % 3 == 0) ? "x" : (i % 3 == 1) ? "y" : "z",
                       want.pts[i], got.pts[i]);
            end
          if (want.s_par !== got.s_par) begin
            fails++;
            $display("%0t: param_a: expected %h, actual %h", $time, want.s_par, got.s_par);
          end
          if (want.t_par !== got.t_par) begin
            fails++;
            $display("%0t: param_b: expected %h, actual %h", $time, want.t_par, got.t_par);
          end
          if (want.dist_sq !== got.dist_sq) begin
            fails++;
            $display("%0t: dist_squared: expected %h, actual %h", $time, want.dist_sq,
                     got.dist_sq);
          end
        end
      end
      pending = expected_q.size();
    end
  end

endmodule

[tb/tb_segment_segment_closest_points.sv]
// Testbench top for the segment closest-points pipeline: drives segment pairs
// and threshold settings with random gaps and stalls, and gives the verdict.
// Depends on scsp_pkg, scsp_checker and the block itself.
`timescale 1ns / 1ps

module tb_segment_segment_closest_points;
  import scsp_pkg::*;

  typedef enum int {
    PAIR_FULL, PAIR_SMALL, PAIR_DEGEN_A, PAIR_DEGEN_B, PAIR_PARALLEL, PAIR_TINY
  } pair_kind_e;

  localparam int DRAIN_CYCLES = 60;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [383:0]     s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [295:0]     m_axis_tdata;
  logic             cfg_we_i = 1'b0;
  logic [THR_W-1:0] cfg_wdata_i = '0;
  int               fail_count;
  int               pending;
  logic             pair_taken;
  logic             hold_off_req = 1'b0;
  logic             no_gaps = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  segment_segment_closest_points dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_wdata_i
  );

  scsp_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Acceptance seen at the last rising edge, read at the falling edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_taken <= 1'b0;
    end else begin
      pair_taken <= s_axis_tvalid && s_axis_tready;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] coord(input bit wide_range);
    if (wide_range) return $urandom;
    return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
  endfunction

  // Builds one segment pair of the given kind with random content.
  function automatic logic [383:0] make_pair(input pair_kind_e kind);
    logic [11:0][31:0] v;
    int k;
    for (int i = 0; i < 12; i++) v[i] = coord(kind == PAIR_FULL);
    case (kind)
      PAIR_DEGEN_A: begin
        for (int i = 0; i < 3; i++) v[3+i] = v[i] + $urandom_range(0, 40) - 20;
      end
      PAIR_DEGEN_B: begin
        for (int i = 0; i < 3; i++) v[9+i] = v[6+i] + $urandom_range(0, 40) - 20;
      end
      PAIR_PARALLEL: begin
        k = $urandom_range(1, 3);
        for (int i = 0; i < 3; i++) begin
          v[3+i] = v[i] + (($urandom_range(0, 4096) - 2048) <<< 4);
          v[9+i] = v[6+i] + (v[3+i] - v[i]) * k;
        end
      end
      PAIR_TINY: begin
        for (int i = 0; i < 12; i++) v[i] = $urandom_range(0, 600) - 300;
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_pair(input logic [383:0] pair);
    int gap;
    gap = no_gaps ? 0 : gap_len();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = pair;
    s_axis_tvalid = 1'b1;
    do @(negedge clk_i); while (!pair_taken);
  endtask

  task automatic send_coords(input logic [31:0] ax, ay, az, bx, by, bz,
                             cx, cy, cz, dx, dy, dz);
    send_pair({dz, dy, dx, cz, cy, cx, bz, by, bx, az, ay, ax});
  endtask

  task automatic send_random(input int count);
    pair_kind_e kind;
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      kind = (r < 25) ? PAIR_FULL : (r < 55) ? PAIR_SMALL : (r < 67) ? PAIR_DEGEN_A :
             (r < 79) ? PAIR_DEGEN_B : (r < 90) ? PAIR_PARALLEL : PAIR_TINY;
      send_pair(make_pair(kind));
    end
  endtask

  // Threshold writes happen only with the pipeline empty.
  task automatic write_threshold(input logic [THR_W-1:0] value);
    s_axis_tvalid = 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_wdata_i = value;
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // Output side: random stalls, plus one long hold-off on request.
  initial begin
    int stall;
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !held) begin
        m_axis_tready = 1'b0;
        repeat (300) @(negedge clk_i);
        held = 1'b1;
      end
      stall = gap_len();
      m_axis_tready = 1'b0;
      if (stall > 0) repeat (stall) @(negedge clk_i);
      m_axis_tready = 1'b1;
      repeat ($urandom_range(0, 20)) @(negedge clk_i);
    end
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  localparam logic [31:0] MAXC = 32'h7FFF_FFFF;
  localparam logic [31:0] MINC = 32'h8000_0000;
  localparam logic [31:0] ONE  = 32'h0001_0000;

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed pairs at the reset threshold.
    send_coords(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);                 // both points
    send_coords(MAXC, MAXC, MAXC, MINC, MINC, MINC,
                MINC, MAXC, MINC, MAXC, MINC, MAXC);                 // extremes
    send_coords(MINC, MINC, MINC, MAXC, MAXC, MAXC,
                MAXC, MAXC, MAXC, MAXC, MAXC, MAXC);                 // B a point at A's far end
    send_coords(5, 5, 5, 6, 5, 5, 0, 0, 0, 4*ONE, ONE, 0);           // A degenerate
    send_coords(0, 0, 0, 4*ONE, 0, 0, ONE, ONE, 0, ONE, ONE, 1);     // B degenerate
    send_coords(0, 0, 0, 4*ONE, 0, 0, 0, ONE, 0, 4*ONE, ONE, 0);     // parallel
    send_coords(0, 0, 0, 4*ONE, 0, 0, ONE, ONE, 0, ONE, -ONE, 0);    // crossing
    send_coords(0, 0, 0, 4*ONE, 0, 0, ONE, ONE, 0, ONE, 3*ONE, 0);   // t below zero
    send_coords(0, 0, 0, 4*ONE, 0, 0, ONE, -3*ONE, 0, ONE, -ONE, 0); // t above one
    send_coords(0, 0, 0, ONE, 0, 0, 3*ONE, ONE, 0, 3*ONE, -ONE, 1);  // s clamped to one
    send_coords(0, 0, 0, ONE, 0, 0, -3*ONE, ONE, 0, -3*ONE, -ONE, 0);// s clamped to zero
    send_coords(1, 2, 3, 7, -5, 11, -9, 4, 2, 13, 8, -6);            // rounding
    send_random(90);

    // Long receiver hold-off while the sender keeps offering pairs.
    no_gaps = 1'b1;
    hold_off_req = 1'b1;
    send_random(120);
    no_gaps = 1'b0;

    // Zero threshold: only exact points are degenerate.
    write_threshold('0);
    send_coords(0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    send_coords(7, 7, 7, 7, 7, 7, 0, 0, 0, 0, 1, 0);
    send_random(90);

    write_threshold({THR_W{1'b1}});
    send_random(90);

    write_threshold($urandom);
    send_random(60);

    write_threshold(THR_RESET);
    send_random(60);

    s_axis_tvalid = 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/scsp_pkg.sv
hw/rtl/scsp_delay.sv
hw/rtl/scsp_div.sv
hw/rtl/scsp_point.sv
hw/rtl/segment_segment_closest_points.sv
tb/scsp_checker.sv
tb/tb_segment_segment_closest_points.sv
